FILE: sv/lwst_pkg.sv
// ----------------------------------------------------------------------------
// lwst_pkg
// shared types, constants and the arctangent table of the stop trigger
// ----------------------------------------------------------------------------
`default_nettype none

package lwst_pkg;

    localparam int XW = 36;
    localparam int ZW = 34;
    localparam int CW = 17;

    localparam logic [15:0] KINV = 16'd39797;
    localparam logic signed [CW-1:0] CLOSEST_NONE = 17'sd65535;
    localparam logic signed [CW-1:0] CLOSEST_MIN  = 17'sh1_0000;

    localparam logic [2:0] REG_WINDOW_WIDTH = 3'd0;
    localparam logic [2:0] REG_SENSITIVE    = 3'd1;
    localparam logic [2:0] REG_RELEASE_HYST = 3'd2;
    localparam logic [2:0] REG_RANGE_FLOOR  = 3'd3;
    localparam logic [2:0] REG_START_ANGLE  = 3'd4;
    localparam logic [2:0] REG_ANGLE_STEP   = 3'd5;

    typedef struct packed {
        logic capture;
        logic init;
        logic rotate;
        logic update;
        logic advance;
        logic close;
    } cmd_t;

    typedef struct packed {
        logic above_floor;
        logic iter_last;
        logic last;
        logic out_busy;
    } sts_t;

    // atan(2^-i) in 2^32 units per turn
    function automatic logic [29:0] atan_at(input logic [4:0] i);
        logic [29:0] a;
        case (i)
            5'd0:    a = 30'd536870912;
            5'd1:    a = 30'd316933406;
            5'd2:    a = 30'd167458907;
            5'd3:    a = 30'd85004756;
            5'd4:    a = 30'd42667331;
            5'd5:    a = 30'd21354465;
            5'd6:    a = 30'd10679838;
            5'd7:    a = 30'd5340245;
            5'd8:    a = 30'd2670163;
            5'd9:    a = 30'd1335087;
            5'd10:   a = 30'd667544;
            5'd11:   a = 30'd333772;
            5'd12:   a = 30'd166886;
            5'd13:   a = 30'd83443;
            5'd14:   a = 30'd41722;
            5'd15:   a = 30'd20861;
            5'd16:   a = 30'd10430;
            5'd17:   a = 30'd5215;
            5'd18:   a = 30'd2608;
            5'd19:   a = 30'd1304;
            5'd20:   a = 30'd652;
            5'd21:   a = 30'd326;
            5'd22:   a = 30'd163;
            5'd23:   a = 30'd81;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

FILE: sv/lwst_ctrl.sv
// ----------------------------------------------------------------------------
// lwst_ctrl
// sequencer for one beam: capture, cordic iterations, corridor test, scan end
// ----------------------------------------------------------------------------
`default_nettype none

module lwst_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  lwst_pkg::sts_t     sts,
    output lwst_pkg::cmd_t     cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_INIT  = 5'b00010,
        ST_ROT   = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_END   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (sts.above_floor)
                begin
                    cmd.init   = 1'b1;
                    state_next = ST_ROT;
                end
                else
                begin
                    state_next = ST_END;
                end
            end
            ST_ROT:
            begin
                cmd.rotate = 1'b1;
                if (sts.iter_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.update = 1'b1;
                state_next = ST_END;
            end
            ST_END:
            begin
                if (!sts.last)
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (!sts.out_busy)
                begin
                    cmd.close  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/lwst_dp.sv
// ----------------------------------------------------------------------------
// lwst_dp
// datapath: config registers, iterative cordic, corridor test, closest point,
// stop flag hysteresis and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module lwst_dp #(
    parameter int CORDIC_STAGES = 16,
    parameter int RANGE_BITS    = 16,
    parameter int ANGLE_BITS    = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire logic [15:0]          range_mm,
    input  wire logic                 last_of_scan,
    input  lwst_pkg::cmd_t            cmd,
    output lwst_pkg::sts_t            sts,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      stop_active,
    output logic signed [16:0]        closest_ahead_mm
);

    localparam int XW = lwst_pkg::XW;
    localparam int ZW = lwst_pkg::ZW;
    localparam int CW = lwst_pkg::CW;
    localparam int IW = $clog2(CORDIC_STAGES);
    localparam int RW = (RANGE_BITS < 16) ? RANGE_BITS : 16;
    localparam logic [15:0] RMASK = 16'((32'd1 << RW) - 32'd1);
    localparam logic [31:0] START_RST32 = 32'hFFFF_8000;
    localparam logic [ANGLE_BITS-1:0] BEAM_RST = START_RST32[ANGLE_BITS-1:0];

    // configuration
    logic [15:0] width_reg;
    logic [14:0] sens_reg;
    logic [14:0] hyst_reg;
    logic [15:0] floor_reg;
    logic [15:0] start_reg;
    logic [15:0] step_reg;

    // scan state
    logic [ANGLE_BITS-1:0] beam_reg;
    logic [ANGLE_BITS-1:0] beam_next;
    logic signed [CW-1:0]  closest_reg;
    logic signed [CW-1:0]  closest_next;
    logic                  stop_reg;
    logic                  stop_next;

    // item and cordic
    logic [15:0]           r_reg;
    logic                  last_reg;
    logic signed [XW-1:0]  x_reg;
    logic signed [XW-1:0]  x_next;
    logic signed [XW-1:0]  y_reg;
    logic signed [XW-1:0]  y_next;
    logic signed [ZW-1:0]  z_reg;
    logic signed [ZW-1:0]  z_next;
    logic [IW-1:0]         cnt_reg;
    logic [IW-1:0]         cnt_next;

    // output word
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_stop_reg;
    logic                  out_stop_next;
    logic signed [CW-1:0]  out_closest_reg;
    logic signed [CW-1:0]  out_closest_next;

    logic signed [31:0]    start32;
    logic signed [31:0]    step32;
    logic signed [31:0]    cfg32;
    logic [31:0]           zu;
    logic [31:0]           zf;
    logic                  fold;
    logic [31:0]           prod;
    logic signed [XW-1:0]  x_pos;
    logic signed [XW-1:0]  dx;
    logic signed [XW-1:0]  dy;
    logic signed [ZW-1:0]  atan_z;
    logic [XW-1:0]         ay;
    logic                  in_window;
    logic signed [XW:0]    x_round;
    logic signed [XW-16:0] xr;
    logic signed [CW-1:0]  xr_sat;
    logic signed [17:0]    closest_w;
    logic signed [17:0]    sens_w;
    logic signed [17:0]    release_w;
    logic                  changed;

    assign start32 = 32'(signed'(start_reg));
    assign step32  = 32'(signed'(step_reg));
    assign cfg32   = 32'(signed'(cfg_data));

    assign zu     = {beam_reg, {(32 - ANGLE_BITS){1'b0}}};
    assign fold   = zu[31] ^ zu[30];
    assign zf     = fold ? (zu + 32'h8000_0000) : zu;
    assign prod   = 32'(r_reg) * 32'(lwst_pkg::KINV);
    assign x_pos  = signed'({{(XW - 32){1'b0}}, prod});

    assign dx     = y_reg >>> cnt_reg;
    assign dy     = x_reg >>> cnt_reg;
    assign atan_z = signed'({{(ZW - 30){1'b0}}, lwst_pkg::atan_at(5'(cnt_reg))});

    assign ay        = y_reg[XW-1] ? XW'(-y_reg) : XW'(y_reg);
    assign in_window = {1'b0, ay, 1'b0} < {{(XW - 30){1'b0}}, width_reg, 16'h0000};
    assign x_round   = (XW + 1)'(x_reg) + (XW + 1)'(32768);
    assign xr        = x_round[XW:16];

    always_comb
    begin
        if (xr > (XW - 15)'(signed'(lwst_pkg::CLOSEST_NONE)))
        begin
            xr_sat = lwst_pkg::CLOSEST_NONE;
        end
        else if (xr < (XW - 15)'(signed'(lwst_pkg::CLOSEST_MIN)))
        begin
            xr_sat = lwst_pkg::CLOSEST_MIN;
        end
        else
        begin
            xr_sat = CW'(xr);
        end
    end

    assign closest_w = 18'(closest_reg);
    assign sens_w    = signed'({3'b000, sens_reg});
    assign release_w = signed'({2'b00, 16'({1'b0, sens_reg} + {1'b0, hyst_reg})});
    assign changed   = stop_reg ? (closest_w > release_w) : (closest_w < sens_w);

    assign sts.above_floor = r_reg > floor_reg;
    assign sts.iter_last   = (cnt_reg == IW'(CORDIC_STAGES - 1));
    assign sts.last        = last_reg;
    assign sts.out_busy    = out_valid_reg & ~out_ready;

    assign out_valid        = out_valid_reg;
    assign stop_active      = out_stop_reg;
    assign closest_ahead_mm = out_closest_reg;

    always_comb
    begin
        beam_next = beam_reg;
        if (cmd.advance)
        begin
            beam_next = beam_reg + step32[ANGLE_BITS-1:0];
        end
        if (cmd.close)
        begin
            beam_next = start32[ANGLE_BITS-1:0];
        end
        if (cfg_we && (cfg_index == lwst_pkg::REG_START_ANGLE))
        begin
            beam_next = cfg32[ANGLE_BITS-1:0];
        end
    end

    always_comb
    begin
        closest_next     = closest_reg;
        stop_next        = stop_reg;
        out_valid_next   = out_valid_reg & ~out_ready;
        out_stop_next    = out_stop_reg;
        out_closest_next = out_closest_reg;
        if (cmd.update && in_window && (xr_sat < closest_reg))
        begin
            closest_next = xr_sat;
        end
        if (cmd.close)
        begin
            closest_next = lwst_pkg::CLOSEST_NONE;
            if (changed)
            begin
                stop_next        = ~stop_reg;
                out_valid_next   = 1'b1;
                out_stop_next    = ~stop_reg;
                out_closest_next = closest_reg;
            end
        end
    end

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        z_next   = z_reg;
        cnt_next = cnt_reg;
        if (cmd.init)
        begin
            x_next   = fold ? -x_pos : x_pos;
            y_next   = '0;
            z_next   = ZW'(signed'(zf));
            cnt_next = '0;
        end
        else if (cmd.rotate)
        begin
            if (!z_reg[ZW-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_z;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_z;
            end
            cnt_next = cnt_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 16'd2000;
            sens_reg      <= 15'd1000;
            hyst_reg      <= 15'd200;
            floor_reg     <= 16'd100;
            start_reg     <= START_RST32[15:0];
            step_reg      <= 16'd91;
            beam_reg      <= BEAM_RST;
            closest_reg   <= lwst_pkg::CLOSEST_NONE;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    lwst_pkg::REG_WINDOW_WIDTH: width_reg <= cfg_data;
                    lwst_pkg::REG_SENSITIVE:    sens_reg  <= cfg_data[14:0];
                    lwst_pkg::REG_RELEASE_HYST: hyst_reg  <= cfg_data[14:0];
                    lwst_pkg::REG_RANGE_FLOOR:  floor_reg <= cfg_data;
                    lwst_pkg::REG_START_ANGLE:  start_reg <= cfg_data;
                    lwst_pkg::REG_ANGLE_STEP:   step_reg  <= cfg_data;
                    default:                    ;
                endcase
            end
            beam_reg      <= beam_next;
            closest_reg   <= closest_next;
            stop_reg      <= stop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            r_reg    <= range_mm & RMASK;
            last_reg <= last_of_scan;
        end
        x_reg           <= x_next;
        y_reg           <= y_next;
        z_reg           <= z_next;
        cnt_reg         <= cnt_next;
        out_stop_reg    <= out_stop_next;
        out_closest_reg <= out_closest_next;
    end

endmodule

`default_nettype wire

FILE: sv/lidar_window_stop_trigger_top.sv
// ----------------------------------------------------------------------------
// lidar_window_stop_trigger_top
// lidar obstacle stop trigger: rotates each beam into the vehicle frame,
// keeps the closest point in the corridor and applies stop hysteresis
//
//   channel  signals                                  dir   role
//   in       in_valid/in_ready, range_mm,              in    one beam per word
//            last_of_scan
//   out      out_valid/out_ready, stop_active,         out   stop flag changes
//            closest_ahead_mm
//   cfg      cfg_we, cfg_index, cfg_data               in    register writes
//
// a beam above the range floor passes through the init, rotate, check and end
// states, iterating in rotate on the single shared cordic iteration unit; a
// beam at or below the floor goes from init straight to end
// reset loads the register defaults, clears the stop flag and the closest point
// the output register holds a word while out_ready is low; only the scan-end
// beam waits for it to drain
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_window_stop_trigger_top #(
    parameter int CORDIC_STAGES = 16,
    parameter int RANGE_BITS    = 16,
    parameter int ANGLE_BITS    = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [15:0]        range_mm,
    input  wire logic               last_of_scan,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    stop_active,
    output logic signed [16:0]      closest_ahead_mm
);

    lwst_pkg::cmd_t cmd;
    lwst_pkg::sts_t sts;

    lwst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lwst_dp #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .RANGE_BITS    (RANGE_BITS),
        .ANGLE_BITS    (ANGLE_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .range_mm         (range_mm),
        .last_of_scan     (last_of_scan),
        .cmd              (cmd),
        .sts              (sts),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .stop_active      (stop_active),
        .closest_ahead_mm (closest_ahead_mm)
    );

endmodule

`default_nettype wire

FILE: sv/lwst_checker.sv
// ----------------------------------------------------------------------------
// lwst_checker
// port-level checks of the stop trigger, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module lwst_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic               stop_active,
    input  wire logic signed [16:0] closest_ahead_mm
);

    logic flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            flag_reg <= stop_active;
        end
    end

    // a held word keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(stop_active)
            && $stable(closest_ahead_mm))
        else $error("output word changed while stalled");

    // words only report flag changes, so they alternate starting from set
    a_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> stop_active != flag_reg)
        else $error("stop flag word repeats previous value");

    // a release needs a closest point beyond a non-negative threshold
    a_release_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !stop_active |-> !closest_ahead_mm[16] && closest_ahead_mm != 17'sd0)
        else $error("release with closest point not ahead");

    // a set needs a closest point below the largest sensitive range
    a_set_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stop_active |-> closest_ahead_mm < 17'sd32767)
        else $error("set with closest point out of range");

    // each beam keeps the block busy, so in_ready is low right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("beam accepted on consecutive cycles");

endmodule

bind lidar_window_stop_trigger_top lwst_checker u_lwst_checker (.*);

`default_nettype wire

FILE: dv/tb_lidar_window_stop_trigger_top.sv
// ----------------------------------------------------------------------------
// tb_lidar_window_stop_trigger_top
// self-checking testbench for the lidar obstacle stop trigger: beams are sent
// scan by scan with random gaps, a bit-exact cordic and hysteresis predictor
// tracks every accepted beam, and each stop flag change word is compared with
// the oldest predicted change while the output side stalls at random
// ----------------------------------------------------------------------------
module tb_lidar_window_stop_trigger_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CORDIC_STAGES  = 16;
    localparam int SETTLE_CYCLES  = 48;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int RANDOM_BEAMS   = 950;
    localparam int PHASE_BEAMS    = 160;

    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {
        SCAN_OBSTACLE,
        SCAN_CLEAR,
        SCAN_NOISE
    } scan_kind_t;

    typedef struct packed {
        logic               stop;
        logic signed [16:0] closest;
    } flag_change_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [15:0]        range_mm = '0;
    logic               last_of_scan = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               stop_active;
    logic signed [16:0] closest_ahead_mm;

    // atan(2^-i) in 2^32 units per turn
    longint arctan_q32 [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    // predictor state
    logic [15:0]  corridor_width_mm;
    logic [14:0]  stop_below_mm;
    logic [14:0]  release_margin_mm;
    logic [15:0]  floor_mm;
    logic [15:0]  first_beam_angle;
    logic [15:0]  beam_step;
    logic [15:0]  next_beam_angle;
    int           scan_closest_mm;
    logic         stop_state;

    flag_change_t expected_changes [$];

    int feed_gap_max = 0;
    int drain_stall_max = 0;
    int failures = 0;
    int cycle_count = 0;

    lidar_window_stop_trigger_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .range_mm         (range_mm),
        .last_of_scan     (last_of_scan),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .stop_active      (stop_active),
        .closest_ahead_mm (closest_ahead_mm)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("lidar_window_stop_trigger_top test failed");
            $finish;
        end
    end

    function automatic void load_register_defaults();
        corridor_width_mm = 16'd2000;
        stop_below_mm     = 15'd1000;
        release_margin_mm = 15'd200;
        floor_mm          = 16'd100;
        first_beam_angle  = 16'h8000;
        beam_step         = 16'd91;
        next_beam_angle   = 16'h8000;
        scan_closest_mm   = int'(lwst_pkg::CLOSEST_NONE);
        stop_state        = 1'b0;
    endfunction

    function automatic void apply_register(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            lwst_pkg::REG_WINDOW_WIDTH: corridor_width_mm = data;
            lwst_pkg::REG_SENSITIVE:    stop_below_mm = data[14:0];
            lwst_pkg::REG_RELEASE_HYST: release_margin_mm = data[14:0];
            lwst_pkg::REG_RANGE_FLOOR:  floor_mm = data;
            lwst_pkg::REG_START_ANGLE:
            begin
                first_beam_angle = data;
                next_beam_angle  = data;
            end
            lwst_pkg::REG_ANGLE_STEP:   beam_step = data;
            default:                    ;
        endcase
    endfunction

    // polar to cartesian in q16 mm, gain compensated
    function automatic void rotate_beam(input logic [15:0] r, input logic [15:0] ang,
                                        output longint x, output longint y);
        logic [31:0] zu;
        longint      z;
        longint      dx;
        longint      dy;
        zu = {ang, 16'h0000};
        x = longint'(r) * longint'(lwst_pkg::KINV);
        y = 0;
        if (zu[31:30] == 2'b01 || zu[31:30] == 2'b10)
        begin
            x = -x;
            zu = zu + 32'h8000_0000;
        end
        z = longint'(signed'(zu));
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_q32[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_q32[i];
            end
        end
    endfunction

    function automatic void track_beam(input logic [15:0] r, input logic last);
        longint       x;
        longint       y;
        longint       ay;
        longint       xr;
        logic         changed;
        flag_change_t change;
        if (r > floor_mm)
        begin
            rotate_beam(r, next_beam_angle, x, y);
            ay = (y < 0) ? -y : y;
            if (2 * ay < (longint'(corridor_width_mm) << 16))
            begin
                xr = (x + 32768) >>> 16;
                if (xr > longint'(lwst_pkg::CLOSEST_NONE))
                    xr = longint'(lwst_pkg::CLOSEST_NONE);
                if (xr < longint'(lwst_pkg::CLOSEST_MIN))
                    xr = longint'(lwst_pkg::CLOSEST_MIN);
                if (int'(xr) < scan_closest_mm)
                    scan_closest_mm = int'(xr);
            end
        end
        next_beam_angle = next_beam_angle + beam_step;
        if (last)
        begin
            changed = 1'b0;
            if (!stop_state)
            begin
                if (scan_closest_mm < int'(stop_below_mm))
                begin
                    stop_state = 1'b1;
                    changed = 1'b1;
                end
            end
            else if (scan_closest_mm > int'(stop_below_mm) + int'(release_margin_mm))
            begin
                stop_state = 1'b0;
                changed = 1'b1;
            end
            if (changed)
            begin
                change = '{stop: stop_state, closest: scan_closest_mm[16:0]};
                expected_changes.insert(expected_changes.size(), change);
            end
            scan_closest_mm = int'(lwst_pkg::CLOSEST_NONE);
            next_beam_angle = first_beam_angle;
        end
    endfunction

    task automatic send_beam(input logic [15:0] r, input logic last);
        int gap;
        gap = $urandom_range(0, feed_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        range_mm     <= r;
        last_of_scan <= last;
        do
            @(posedge clk);
        while (!in_ready);
        track_beam(r, last);
    endtask

    // drain all pending words, then give an in-flight beam time to finish
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_changes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_register(idx, data);
        @(posedge clk);
    endtask

    // output side: random stall before each word, then check it
    initial
    begin
        flag_change_t want;
        int           stall;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            stall = $urandom_range(0, drain_stall_max);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            if (expected_changes.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected word: stop_active=%0b closest_ahead_mm=%0d",
                             stop_active, closest_ahead_mm);
            end
            else
            begin
                want = expected_changes.pop_front();
                if (stop_active !== want.stop || closest_ahead_mm !== want.closest)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("mismatch: expected stop_active=%0b closest_ahead_mm=%0d, ",
                                 want.stop, want.closest,
                                 "got stop_active=%0b closest_ahead_mm=%0d",
                                 stop_active, closest_ahead_mm);
                end
            end
        end
    end

    task automatic test_reset_defaults();
        feed_gap_max    = 18;
        drain_stall_max = 18;
        // beams behind the vehicle give negative x and set stop
        send_beam(16'd0, 1'b0);
        send_beam(16'd100, 1'b0);
        send_beam(16'd101, 1'b1);
        send_beam(16'hFFFF, 1'b1);
        // nothing in corridor releases
        send_beam(16'd50, 1'b1);
        settle();
    endtask

    task automatic test_register_extremes();
        feed_gap_max    = 0;
        drain_stall_max = 0;
        // zero width corridor never holds a point
        write_register(lwst_pkg::REG_WINDOW_WIDTH, 16'd0);
        write_register(lwst_pkg::REG_START_ANGLE, 16'd0);
        write_register(lwst_pkg::REG_ANGLE_STEP, 16'd0);
        send_beam(16'd5000, 1'b1);
        settle();
        write_register(lwst_pkg::REG_WINDOW_WIDTH, 16'hFFFF);
        write_register(lwst_pkg::REG_RANGE_FLOOR, 16'd0);
        write_register(lwst_pkg::REG_SENSITIVE, 16'h7FFF);
        write_register(lwst_pkg::REG_RELEASE_HYST, 16'h7FFF);
        send_beam(16'd1, 1'b0);
        send_beam(16'hFFFF, 1'b1);
        // saturated x looks like no point and releases
        send_beam(16'hFFFF, 1'b1);
        settle();
        write_register(lwst_pkg::REG_RANGE_FLOOR, 16'hFFFF);
        send_beam(16'hFFFF, 1'b1);
        settle();
        feed_gap_max    = 18;
        drain_stall_max = 18;
        write_register(lwst_pkg::REG_SENSITIVE, 16'd0);
        write_register(lwst_pkg::REG_RANGE_FLOOR, 16'd0);
        write_register(lwst_pkg::REG_START_ANGLE, 16'h8000);
        send_beam(16'd2, 1'b1);
        settle();
        write_register(lwst_pkg::REG_RELEASE_HYST, 16'd0);
        send_beam(16'd0, 1'b1);
        settle();
        // top bit of the 15-bit registers is dropped
        write_register(lwst_pkg::REG_SENSITIVE, 16'hFFFF);
        write_register(lwst_pkg::REG_START_ANGLE, 16'h7FFF);
        write_register(lwst_pkg::REG_ANGLE_STEP, 16'd1);
        send_beam(16'd300, 1'b0);
        send_beam(16'd300, 1'b1);
        settle();
        write_register(lwst_pkg::REG_ANGLE_STEP, 16'h8000);
        send_beam(16'd400, 1'b0);
        send_beam(16'd400, 1'b0);
        send_beam(16'd400, 1'b1);
        settle();
    endtask

    task automatic test_start_angle_reload();
        feed_gap_max    = 18;
        drain_stall_max = 18;
        write_register(lwst_pkg::REG_WINDOW_WIDTH, 16'd2000);
        write_register(lwst_pkg::REG_SENSITIVE, 16'd1000);
        write_register(lwst_pkg::REG_RELEASE_HYST, 16'd200);
        write_register(lwst_pkg::REG_RANGE_FLOOR, 16'd100);
        write_register(lwst_pkg::REG_ANGLE_STEP, 16'd91);
        write_register(lwst_pkg::REG_START_ANGLE, 16'd0);
        send_beam(16'd500, 1'b0);
        settle();
        // mid-scan reload: closest point is kept, next beam points sideways
        write_register(lwst_pkg::REG_START_ANGLE, 16'h4000);
        send_beam(16'd3000, 1'b1);
        send_beam(16'd50, 1'b1);
        settle();
    endtask

    task automatic test_unused_register_index();
        write_register(REG_SPARE_6, 16'($urandom_range(0, 65535)));
        write_register(REG_SPARE_7, 16'($urandom_range(0, 65535)));
        send_beam(16'd700, 1'b1);
        send_beam(16'd50, 1'b1);
        settle();
    endtask

    task automatic test_random_scans();
        int          phase;
        int          random_beams;
        int          phase_beams;
        int          n;
        int          roll;
        bit          wild;
        scan_kind_t  kind;
        logic [15:0] r;
        logic        last;
        phase = 0;
        random_beams = 0;
        while (random_beams < RANDOM_BEAMS)
        begin
            settle();
            wild = (phase % 4 == 3);
            if (wild)
            begin
                write_register(lwst_pkg::REG_WINDOW_WIDTH, 16'($urandom_range(0, 65535)));
                write_register(lwst_pkg::REG_SENSITIVE, 16'($urandom_range(0, 65535)));
                write_register(lwst_pkg::REG_RELEASE_HYST, 16'($urandom_range(0, 65535)));
                write_register(lwst_pkg::REG_RANGE_FLOOR, 16'($urandom_range(0, 65535)));
                write_register(lwst_pkg::REG_START_ANGLE, 16'($urandom_range(0, 65535)));
                write_register(lwst_pkg::REG_ANGLE_STEP, 16'($urandom_range(0, 65535)));
            end
            else
            begin
                write_register(lwst_pkg::REG_WINDOW_WIDTH, 16'($urandom_range(400, 4000)));
                write_register(lwst_pkg::REG_SENSITIVE, 16'($urandom_range(200, 3000)));
                write_register(lwst_pkg::REG_RELEASE_HYST, 16'($urandom_range(0, 800)));
                write_register(lwst_pkg::REG_RANGE_FLOOR, 16'($urandom_range(0, 300)));
                write_register(lwst_pkg::REG_START_ANGLE,
                               16'($urandom_range(0, 8000) - 4000));
                write_register(lwst_pkg::REG_ANGLE_STEP,
                               16'($urandom_range(0, 400) - 200));
            end
            feed_gap_max    = $urandom_range(0, 2) * 9;
            drain_stall_max = $urandom_range(0, 2) * 9;
            phase_beams = 0;
            while (phase_beams < PHASE_BEAMS)
            begin
                roll = $urandom_range(0, 9);
                if (roll == 0)
                    kind = SCAN_NOISE;
                else if (roll <= 7)
                    kind = stop_state ? SCAN_CLEAR : SCAN_OBSTACLE;
                else
                    kind = $urandom_range(0, 1) ? SCAN_CLEAR : SCAN_OBSTACLE;
                n = $urandom_range(1, 12);
                for (int b = 0; b < n; b++)
                begin
                    last = (b == n - 1);
                    case (kind)
                        SCAN_OBSTACLE:
                            r = $urandom_range(0, 1)
                                ? 16'($urandom_range(int'(floor_mm) + 1,
                                                     int'(stop_below_mm)))
                                : 16'($urandom_range(0, 65535));
                        SCAN_CLEAR:
                            r = $urandom_range(0, 1)
                                ? 16'($urandom_range(0, int'(floor_mm)))
                                : 16'($urandom_range(int'(stop_below_mm)
                                                     + int'(release_margin_mm) + 200,
                                                     65535));
                        default:
                        begin
                            r = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(0, 255));
                            last = ($urandom_range(0, 3) == 0);
                        end
                    endcase
                    send_beam(r, last);
                end
                phase_beams += n;
            end
            random_beams += phase_beams;
            phase++;
        end
        settle();
    endtask

    initial
    begin
        load_register_defaults();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_start_angle_reload();
        test_unused_register_index();
        test_random_scans();
        failures += expected_changes.size();
        if (failures == 0)
            $display("lidar_window_stop_trigger_top test passed");
        else
            $display("lidar_window_stop_trigger_top test failed");
        $finish;
    end

endmodule
